### sv/cdda_pkg.sv
// ----------------------------------------------------------------------------
// cdda_pkg
// Shared widths, constants, command/status types and calendar helpers
// for the calendar date day adder.
// ----------------------------------------------------------------------------
package cdda_pkg;

   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 20;
   localparam int ACC_W   = COUNT_W + 1;

   localparam logic [YEAR_W-1:0]  MAX_YEAR     = 16'd65535;
   localparam logic [YEAR_W-1:0]  DEFAULT_YEAR = 16'd2000;
   localparam logic [MONTH_W-1:0] JANUARY      = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY    = 5'd1;
   localparam logic [DAY_W-1:0]   LAST_DAY     = 5'd31;

   // multiplicative inverse of 25 mod 2^16 and the divisibility bound
   localparam logic [YEAR_W-1:0]  INV25     = 16'd23593;
   localparam logic [YEAR_W-1:0]  DIV25_LIM = 16'd2621;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   typedef struct packed {
      logic start_load;
      logic start_add;
      logic step;
      logic post;
   } cdda_cmd_type;

   typedef struct packed {
      logic add_done;
      logic rsp_busy;
   } cdda_sts_type;

   // leap if div by 4 and (not div by 100 or div by 400)
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic              div25;
      prod  = year * INV25;
      div25 = (prod <= DIV25_LIM);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic               leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

### sv/cdda_ctrl.sv
// ----------------------------------------------------------------------------
// cdda_ctrl
// Sequencer: accepts an item, runs the month carry loop for an addition and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module cdda_ctrl import cdda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_opcode,
   output cdda_cmd_type cmd,
   input  cdda_sts_type sts
);

   typedef enum logic [1:0] {
      IDLE,
      ADD,
      POST
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign req_ready = ready_ff;
   assign accept    = req_valid && ready_ff;

   always_comb begin
      cmd            = '0;
      cmd.start_load = accept && (req_opcode == OP_LOAD);
      cmd.start_add  = accept && (req_opcode == OP_ADD);
      cmd.step       = (state_ff == ADD) && !sts.add_done;
      cmd.post       = (state_ff == POST) && !sts.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  state_ff <= (req_opcode == OP_ADD) ? ADD : POST;
               end
            end
            ADD: begin
               if (sts.add_done) begin
                  state_ff <= POST;
               end
            end
            POST: begin
               if (!sts.rsp_busy) begin
                  ready_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: begin
               ready_ff <= 1'b1;
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### sv/cdda_dp.sv
// ----------------------------------------------------------------------------
// cdda_dp
// Date registers, load check, one-month-per-cycle carry and the output
// register.
// ----------------------------------------------------------------------------
module cdda_dp import cdda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [YEAR_W-1:0]  req_load_year,
   input  logic [MONTH_W-1:0] req_load_month,
   input  logic [DAY_W-1:0]   req_load_day,
   input  logic [COUNT_W-1:0] req_add_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [YEAR_W-1:0]  rsp_prev_year,
   output logic [MONTH_W-1:0] rsp_prev_month,
   output logic [DAY_W-1:0]   rsp_prev_day,
   output logic [YEAR_W-1:0]  rsp_new_year,
   output logic [MONTH_W-1:0] rsp_new_month,
   output logic [DAY_W-1:0]   rsp_new_day,
   output logic               rsp_load_invalid,
   output logic               rsp_year_overflow,
   input  cdda_cmd_type       cmd,
   output cdda_sts_type       sts
);

   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [ACC_W-1:0]   day_ff;
   logic               leap_ff;
   logic [YEAR_W-1:0]  prev_year_ff;
   logic [MONTH_W-1:0] prev_month_ff;
   logic [DAY_W-1:0]   prev_day_ff;
   logic               inv_ff;
   logic               ovf_ff;

   logic               rsp_valid_ff;
   logic [YEAR_W-1:0]  rsp_prev_year_ff;
   logic [MONTH_W-1:0] rsp_prev_month_ff;
   logic [DAY_W-1:0]   rsp_prev_day_ff;
   logic [YEAR_W-1:0]  rsp_new_year_ff;
   logic [MONTH_W-1:0] rsp_new_month_ff;
   logic [DAY_W-1:0]   rsp_new_day_ff;
   logic               rsp_inv_ff;
   logic               rsp_ovf_ff;

   logic [DAY_W-1:0]   cur_len;
   logic [DAY_W-1:0]   load_len;
   logic               load_ok;

   assign cur_len  = month_len(month_ff, leap_ff);
   assign load_len = month_len(req_load_month, is_leap(req_load_year));
   assign load_ok  = (req_load_year != '0) && (load_len != '0) &&
                     (req_load_day != '0) && (req_load_day <= load_len);

   assign sts.add_done = (day_ff <= ACC_W'(cur_len));
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   // date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= YEAR_W'(1);
         month_ff <= JANUARY;
         day_ff   <= ACC_W'(FIRST_DAY);
         leap_ff  <= 1'b0;
         inv_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         leap_ff <= is_leap(year_ff);
         if (cmd.start_load) begin
            inv_ff <= !load_ok;
            ovf_ff <= 1'b0;
            if (load_ok) begin
               year_ff  <= req_load_year;
               month_ff <= req_load_month;
               day_ff   <= ACC_W'(req_load_day);
            end else begin
               year_ff  <= DEFAULT_YEAR;
               month_ff <= JANUARY;
               day_ff   <= ACC_W'(FIRST_DAY);
            end
         end else if (cmd.start_add) begin
            inv_ff <= 1'b0;
            ovf_ff <= 1'b0;
            day_ff <= day_ff + ACC_W'(req_add_count);
         end else if (cmd.step) begin
            if (month_ff == DECEMBER) begin
               if (year_ff == MAX_YEAR) begin
                  day_ff <= ACC_W'(LAST_DAY);
                  ovf_ff <= 1'b1;
               end else begin
                  day_ff   <= day_ff - ACC_W'(cur_len);
                  month_ff <= JANUARY;
                  year_ff  <= year_ff + YEAR_W'(1);
               end
            end else begin
               day_ff   <= day_ff - ACC_W'(cur_len);
               month_ff <= month_ff + MONTH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_load || cmd.start_add) begin
         prev_year_ff  <= year_ff;
         prev_month_ff <= month_ff;
         prev_day_ff   <= day_ff[DAY_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_prev_year_ff  <= prev_year_ff;
         rsp_prev_month_ff <= prev_month_ff;
         rsp_prev_day_ff   <= prev_day_ff;
         rsp_new_year_ff   <= year_ff;
         rsp_new_month_ff  <= month_ff;
         rsp_new_day_ff    <= day_ff[DAY_W-1:0];
         rsp_inv_ff        <= inv_ff;
         rsp_ovf_ff        <= ovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prev_year     = rsp_prev_year_ff;
   assign rsp_prev_month    = rsp_prev_month_ff;
   assign rsp_prev_day      = rsp_prev_day_ff;
   assign rsp_new_year      = rsp_new_year_ff;
   assign rsp_new_month     = rsp_new_month_ff;
   assign rsp_new_day       = rsp_new_day_ff;
   assign rsp_load_invalid  = rsp_inv_ff;
   assign rsp_year_overflow = rsp_ovf_ff;

endmodule

### sv/calendar_date_day_adder.sv
// Load item: the date is loaded on acceptance, then POST writes the output
// register. Add item: the count is added on acceptance, the carry loop steps
// one month per cycle until the day fits, then POST fills the output register.
// One item at a time; the next is accepted while a result waits to be taken.
// Synchronous active-high reset: date 0001-01-01, no result pending.
// ----------------------------------------------------------------------------
// calendar_date_day_adder
// Gregorian date register with checked load and day addition, built as a
// sequencer and a datapath.
// ----------------------------------------------------------------------------
module calendar_date_day_adder import cdda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [YEAR_W-1:0]  req_load_year,
   input  logic [MONTH_W-1:0] req_load_month,
   input  logic [DAY_W-1:0]   req_load_day,
   input  logic [COUNT_W-1:0] req_add_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [YEAR_W-1:0]  rsp_prev_year,
   output logic [MONTH_W-1:0] rsp_prev_month,
   output logic [DAY_W-1:0]   rsp_prev_day,
   output logic [YEAR_W-1:0]  rsp_new_year,
   output logic [MONTH_W-1:0] rsp_new_month,
   output logic [DAY_W-1:0]   rsp_new_day,
   output logic               rsp_load_invalid,
   output logic               rsp_year_overflow
);

   cdda_cmd_type cmd;
   cdda_sts_type sts;

   cdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .cmd        (cmd),
      .sts        (sts)
   );

   cdda_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_load_year     (req_load_year),
      .req_load_month    (req_load_month),
      .req_load_day      (req_load_day),
      .req_add_count     (req_add_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_prev_year     (rsp_prev_year),
      .rsp_prev_month    (rsp_prev_month),
      .rsp_prev_day      (rsp_prev_day),
      .rsp_new_year      (rsp_new_year),
      .rsp_new_month     (rsp_new_month),
      .rsp_new_day       (rsp_new_day),
      .rsp_load_invalid  (rsp_load_invalid),
      .rsp_year_overflow (rsp_year_overflow),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

### verif/tb_calendar_date_day_adder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_date_day_adder
// Self-checking bench for the calendar date day adder. A directed set covers
// leap-year loads, rejected loads, zero counts, year rollover and the year
// ceiling. A random set follows: mostly day additions, with valid loads and
// random-field loads mixed in. A date tracker predicts every result.
// The bench runs three back-pressure phases: receiver stalls, then sender
// gaps, then neither.
// ----------------------------------------------------------------------------
module tb_calendar_date_day_adder;
   import cdda_pkg::*;

   typedef struct packed {
      logic [YEAR_W-1:0]  prev_year;
      logic [MONTH_W-1:0] prev_month;
      logic [DAY_W-1:0]   prev_day;
      logic [YEAR_W-1:0]  new_year;
      logic [MONTH_W-1:0] new_month;
      logic [DAY_W-1:0]   new_day;
      logic               load_invalid;
      logic               year_overflow;
   } date_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = OP_LOAD;
   logic [YEAR_W-1:0]  req_load_year = '0;
   logic [MONTH_W-1:0] req_load_month = '0;
   logic [DAY_W-1:0]   req_load_day = '0;
   logic [COUNT_W-1:0] req_add_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [YEAR_W-1:0]  rsp_prev_year;
   logic [MONTH_W-1:0] rsp_prev_month;
   logic [DAY_W-1:0]   rsp_prev_day;
   logic [YEAR_W-1:0]  rsp_new_year;
   logic [MONTH_W-1:0] rsp_new_month;
   logic [DAY_W-1:0]   rsp_new_day;
   logic               rsp_load_invalid;
   logic               rsp_year_overflow;

   int tx_idle_pct = 10;
   int rx_idle_pct = 78;
   int long_counts_left = 3;

   calendar_date_day_adder dut (.*);

   always #5 clock = ~clock;

   function automatic bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic string fmt_result(date_result_type r);
      return $sformatf("prev %0d-%0d-%0d new %0d-%0d-%0d inv %0b ovf %0b",
                       r.prev_year, r.prev_month, r.prev_day,
                       r.new_year, r.new_month, r.new_day,
                       r.load_invalid, r.year_overflow);
   endfunction

   class date_tracker;
      int unsigned     cur_year, cur_month, cur_day;
      date_result_type pending_dates[$];
      int              mismatches, checked;
      int              n_loads, n_bad_loads, n_adds, n_overflows;

      function new();
         cur_year  = 1;
         cur_month = 1;
         cur_day   = 1;
      endfunction

      function void note_request(logic op, logic [YEAR_W-1:0] ly,
                                 logic [MONTH_W-1:0] lm, logic [DAY_W-1:0] ld,
                                 logic [COUNT_W-1:0] cnt);
         date_result_type e;
         int unsigned     y, m, d;
         e = '0;
         e.prev_year  = YEAR_W'(cur_year);
         e.prev_month = MONTH_W'(cur_month);
         e.prev_day   = DAY_W'(cur_day);
         if (op == OP_LOAD) begin
            n_loads++;
            if (ly != 0 && lm >= JANUARY && lm <= DECEMBER && ld >= FIRST_DAY &&
                ld <= month_days(32'(ly), 32'(lm))) begin
               cur_year  = 32'(ly);
               cur_month = 32'(lm);
               cur_day   = 32'(ld);
            end else begin
               cur_year  = 32'(DEFAULT_YEAR);
               cur_month = 32'(JANUARY);
               cur_day   = 32'(FIRST_DAY);
               e.load_invalid = 1'b1;
               n_bad_loads++;
            end
         end else begin
            n_adds++;
            y = cur_year;
            m = cur_month;
            d = cur_day + 32'(cnt);
            while (d > month_days(y, m)) begin
               d -= month_days(y, m);
               m++;
               if (m == 13) begin
                  m = 32'(JANUARY);
                  if (y >= MAX_YEAR) begin
                     y = 32'(MAX_YEAR);
                     m = 32'(DECEMBER);
                     d = 32'(LAST_DAY);
                     e.year_overflow = 1'b1;
                     n_overflows++;
                     break;
                  end
                  y++;
               end
            end
            cur_year  = y;
            cur_month = m;
            cur_day   = d;
         end
         e.new_year  = YEAR_W'(cur_year);
         e.new_month = MONTH_W'(cur_month);
         e.new_day   = DAY_W'(cur_day);
         pending_dates.push_back(e);
      endfunction

      function void check_response(date_result_type got);
         date_result_type e;
         checked++;
         if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result: %s", $time, fmt_result(got));
            return;
         end
         e = pending_dates.pop_front();
         if (got.prev_year != e.prev_year || got.prev_month != e.prev_month ||
             got.prev_day != e.prev_day || got.new_year != e.new_year ||
             got.new_month != e.new_month || got.new_day != e.new_day ||
             got.load_invalid != e.load_invalid ||
             got.year_overflow != e.year_overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch, expected %s", $time, fmt_result(e));
               $display("%0t:           actual   %s", $time, fmt_result(got));
            end
         end
      endfunction
   endclass

   date_tracker tracker;

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      date_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.prev_year     = rsp_prev_year;
         got.prev_month    = rsp_prev_month;
         got.prev_day      = rsp_prev_day;
         got.new_year      = rsp_new_year;
         got.new_month     = rsp_new_month;
         got.new_day       = rsp_new_day;
         got.load_invalid  = rsp_load_invalid;
         got.year_overflow = rsp_year_overflow;
         tracker.check_response(got);
      end
   end

   // called just after a rising edge; returns just after the accepting edge
   task automatic send_item(logic op, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                            logic [DAY_W-1:0] d, logic [COUNT_W-1:0] cnt);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_load_year  <= y;
      req_load_month <= m;
      req_load_day   <= d;
      req_add_count  <= cnt;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.note_request(op, y, m, d, cnt);
   endtask

   task automatic send_random(int n);
      int unsigned r, y, m;
      logic [COUNT_W-1:0] cnt;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // load with random field values, well formed or not
            send_item(OP_LOAD, YEAR_W'($urandom()), MONTH_W'($urandom()),
                      DAY_W'($urandom()), COUNT_W'($urandom()));
         end else if (r < 30) begin
            case ($urandom_range(0, 7))
               0:       y = $urandom_range(65500, 65535);
               1:       y = $urandom_range(1, 65535);
               default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(JANUARY, DECEMBER);
            send_item(OP_LOAD, YEAR_W'(y), MONTH_W'(m),
                      DAY_W'($urandom_range(FIRST_DAY, month_days(y, m))),
                      COUNT_W'($urandom()));
         end else begin
            if (long_counts_left > 0 && $urandom_range(0, 39) == 0) begin
               cnt = COUNT_W'($urandom());
               long_counts_left--;
            end else if ($urandom_range(0, 4) == 0) begin
               cnt = COUNT_W'($urandom_range(0, 40000));
            end else begin
               cnt = COUNT_W'($urandom_range(0, 400));
            end
            send_item(OP_ADD, YEAR_W'($urandom()), MONTH_W'($urandom()),
                      DAY_W'($urandom()), cnt);
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'd0);
      send_item(OP_LOAD, 16'd2024,  4'd2,  5'd29, 20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'd1);
      send_item(OP_LOAD, 16'd1900,  4'd2,  5'd29, 20'd0);
      send_item(OP_LOAD, 16'd2000,  4'd2,  5'd29, 20'd0);
      send_item(OP_LOAD, 16'd2023,  4'd2,  5'd29, 20'd0);
      send_item(OP_LOAD, 16'd0,     4'd1,  5'd1,  20'd0);
      send_item(OP_LOAD, 16'd2021,  4'd13, 5'd10, 20'd0);
      send_item(OP_LOAD, 16'd2021,  4'd15, 5'd10, 20'd0);
      send_item(OP_LOAD, 16'd2021,  4'd0,  5'd10, 20'd0);
      send_item(OP_LOAD, 16'd2021,  4'd4,  5'd31, 20'd0);
      send_item(OP_LOAD, 16'd2021,  4'd5,  5'd0,  20'd0);
      send_item(OP_LOAD, 16'd0,     4'd0,  5'd0,  20'd0);
      send_item(OP_LOAD, 16'd65535, 4'd12, 5'd31, 20'hFFFFF);
      send_item(OP_ADD,  16'hFFFF,  4'hF,  5'h1F, 20'd1);
      send_item(OP_LOAD, 16'd65535, 4'd12, 5'd1,  20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'd30);
      send_item(OP_LOAD, 16'd65500, 4'd3,  5'd15, 20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'hFFFFF);
      send_item(OP_LOAD, 16'd2023,  4'd12, 5'd31, 20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'd1);
      send_item(OP_LOAD, 16'd2023,  4'd1,  5'd31, 20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'd29);
      send_item(OP_LOAD, 16'd1,     4'd1,  5'd1,  20'd0);
      send_item(OP_ADD,  16'd0,     4'd0,  5'd0,  20'hFFFFF);

      send_random(25);
      tx_idle_pct = 78;
      rx_idle_pct = 10;
      send_random(25);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(25);
      req_valid <= 1'b0;

      while (tracker.pending_dates.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d results: %0d loads (%0d rejected), %0d additions (%0d overflows)",
               tracker.checked, tracker.n_loads, tracker.n_bad_loads,
               tracker.n_adds, tracker.n_overflows);
      $display("Mismatches: %0d", tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_dates.size() == 0)
         $display("[calendar_date_day_adder] OK");
      else
         $display("[calendar_date_day_adder] ERROR");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Timed out with %0d results outstanding", tracker.pending_dates.size());
      $display("[calendar_date_day_adder] ERROR");
      $finish;
   end

endmodule

### files.f
sv/cdda_pkg.sv
sv/cdda_ctrl.sv
sv/cdda_dp.sv
sv/calendar_date_day_adder.sv
verif/tb_calendar_date_day_adder.sv
